[sv/kteq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kteq_pkg
// Shared types and codes for the keyed timer event queue.
// ----------------------------------------------------------------------------
package kteq_pkg;

  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_SERVICE  = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_FIRED = 3'd2;
  localparam logic [2:0] ST_IDLE  = 3'd3;
  localparam logic [2:0] ST_TICK  = 3'd4;

  typedef struct packed {
    logic [31:0] handler;
    logic [31:0] argument;
    logic [31:0] deadline;
  } entry_t;

  typedef struct packed {
    logic wr_key;
    logic wr_deadline;
    logic set_valid;
    logic clr_valid;
  } wr_cmd_t;

  typedef struct packed {
    logic hit;
    logic free;
    logic better;
  } scan_t;

endpackage

[sv/kteq_slot_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kteq_slot_store
// Slot memories with one registered read port and one write port, plus
// valid flags held in flip-flops.
// ----------------------------------------------------------------------------
module kteq_slot_store #(
  parameter int EVENT_SLOTS = 16,
  parameter int SLOT_W      = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SLOT_W-1:0]      rd_addr,
  output kteq_pkg::entry_t       rd_data,
  output logic [EVENT_SLOTS-1:0] valid,
  input  logic [SLOT_W-1:0]      wr_addr,
  input  kteq_pkg::wr_cmd_t      wr_cmd,
  input  kteq_pkg::entry_t       wr_data
);
  import kteq_pkg::*;

  logic [31:0] mem_handler  [EVENT_SLOTS];
  logic [31:0] mem_argument [EVENT_SLOTS];
  logic [31:0] mem_deadline [EVENT_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_cmd.wr_key) begin
      mem_handler[wr_addr]  <= wr_data.handler;
      mem_argument[wr_addr] <= wr_data.argument;
    end
    if (wr_cmd.wr_deadline) begin
      mem_deadline[wr_addr] <= wr_data.deadline;
    end
    rd_data.handler  <= mem_handler[rd_addr];
    rd_data.argument <= mem_argument[rd_addr];
    rd_data.deadline <= mem_deadline[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_cmd.set_valid) begin
      valid[wr_addr] <= 1'b1;
    end else if (wr_cmd.clr_valid) begin
      valid[wr_addr] <= 1'b0;
    end
  end

endmodule

[sv/kteq_scan_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kteq_scan_unit
// Shared compare unit: key match, free slot and earliest-due test for the
// slot presented in the current scan cycle.
// ----------------------------------------------------------------------------
module kteq_scan_unit (
  input  kteq_pkg::entry_t entry,
  input  logic             entry_valid,
  input  logic [31:0]      key_handler,
  input  logic [31:0]      key_argument,
  input  logic [31:0]      clock_now,
  input  logic             best_found,
  input  logic [31:0]      best_age,
  output logic [31:0]      age,
  output kteq_pkg::scan_t  res
);
  import kteq_pkg::*;

  assign age = clock_now - entry.deadline;

  always_comb begin
    res.hit    = entry_valid && (entry.handler == key_handler)
                 && (entry.argument == key_argument);
    res.free   = !entry_valid;
    res.better = entry_valid && !age[31] && (!best_found || (age > best_age));
  end

endmodule

[sv/keyed_timer_event_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_timer_event_queue
// Table of keyed timer events with a millisecond clock and
// earliest-deadline-first service.
// ----------------------------------------------------------------------------
// usage
//   input beat: opcode, handler_id, argument, delay_ms under in_valid and
//   in_stall. opcode schedule (negative delay cancels), tick or service.
//   output beat: status, fired_handler, fired_argument under out_valid and
//   out_stall, exactly one per input beat, in order.
//   a tick or the unused opcode goes from idle straight to the done step,
//   which loads the output register. schedule and service read every slot
//   once through one memory read port and one compare unit, in the scan,
//   wait, update and done steps in that order; the done step loads the
//   output register.
//   in_stall stays high while a beat is being worked on.
//   a finished result waits in the output register while the next beat is
//   taken; the block holds in its last step while that register is full
//   and stalled.
//   reset clears all valid flags, the clock and the output valid flag; the
//   slot memories are not cleared and are read only behind a valid flag.
// ----------------------------------------------------------------------------
module keyed_timer_event_queue #(
  parameter int EVENT_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [31:0]        handler_id,
  input  logic [31:0]        argument,
  input  logic signed [24:0] delay_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [31:0]        fired_handler,
  output logic [31:0]        fired_argument
);
  import kteq_pkg::*;

  localparam int SLOT_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(EVENT_SLOTS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]         state;
  logic [SLOT_W-1:0]  idx;
  logic               chk_valid;
  logic [SLOT_W-1:0]  chk_idx;
  logic [31:0]        clock_now;

  logic [1:0]         req_op;
  logic [31:0]        req_handler;
  logic [31:0]        req_argument;
  logic signed [24:0] req_delay;

  logic               match_found;
  logic [SLOT_W-1:0]  match_slot;
  logic               free_found;
  logic [SLOT_W-1:0]  free_slot;
  logic               best_found;
  logic [SLOT_W-1:0]  best_slot;
  logic [31:0]        best_age;
  logic [31:0]        best_handler;
  logic [31:0]        best_argument;

  logic [2:0]         res_status;
  logic [31:0]        res_handler;
  logic [31:0]        res_argument;

  entry_t                 rd_data;
  logic [EVENT_SLOTS-1:0] valid;
  logic [SLOT_W-1:0]      wr_addr;
  wr_cmd_t                wr_cmd;
  entry_t                 wr_data;
  logic [31:0]            age;
  scan_t                  scan;
  logic                   accept;
  logic                   out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  kteq_slot_store #(
    .EVENT_SLOTS (EVENT_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (idx),
    .rd_data (rd_data),
    .valid   (valid),
    .wr_addr (wr_addr),
    .wr_cmd  (wr_cmd),
    .wr_data (wr_data)
  );

  kteq_scan_unit u_scan (
    .entry        (rd_data),
    .entry_valid  (valid[chk_idx]),
    .key_handler  (req_handler),
    .key_argument (req_argument),
    .clock_now    (clock_now),
    .best_found   (best_found),
    .best_age     (best_age),
    .age          (age),
    .res          (scan)
  );

  // write port, used only in the update step
  always_comb begin
    wr_cmd           = '0;
    wr_addr          = match_slot;
    wr_data.handler  = req_handler;
    wr_data.argument = req_argument;
    wr_data.deadline = clock_now + {8'd0, req_delay[23:0]};
    if (state == S_UPDATE) begin
      if (req_op == OP_SCHEDULE) begin
        if (req_delay[24]) begin
          wr_cmd.clr_valid = match_found;
        end else if (match_found) begin
          wr_cmd.wr_deadline = 1'b1;
        end else if (free_found) begin
          wr_addr            = free_slot;
          wr_cmd.wr_key      = 1'b1;
          wr_cmd.wr_deadline = 1'b1;
          wr_cmd.set_valid   = 1'b1;
        end
      end else if (req_op == OP_SERVICE) begin
        wr_addr          = best_slot;
        wr_cmd.clr_valid = best_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      chk_valid   <= 1'b0;
      clock_now   <= '0;
      out_valid   <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      best_found  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      if (chk_valid) begin
        if (scan.hit && !match_found) begin
          match_found <= 1'b1;
          match_slot  <= chk_idx;
        end
        if (scan.free && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= chk_idx;
        end
        if (scan.better) begin
          best_found    <= 1'b1;
          best_slot     <= chk_idx;
          best_age      <= age;
          best_handler  <= rd_data.handler;
          best_argument <= rd_data.argument;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_op       <= opcode;
            req_handler  <= handler_id;
            req_argument <= argument;
            req_delay    <= delay_ms;
            match_found  <= 1'b0;
            free_found   <= 1'b0;
            best_found   <= 1'b0;
            idx          <= '0;
            res_handler  <= '0;
            res_argument <= '0;
            case (opcode) inside
              OP_SCHEDULE, OP_SERVICE: begin
                state <= S_SCAN;
              end
              OP_TICK: begin
                clock_now  <= clock_now + 32'd1;
                res_status <= ST_TICK;
                state      <= S_DONE;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          chk_valid <= 1'b1;
          chk_idx   <= idx;
          if (idx == LAST_SLOT) begin
            state <= S_WAIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_WAIT: begin
          chk_valid <= 1'b0;
          state     <= S_UPDATE;
        end
        S_UPDATE: begin
          if (req_op == OP_SCHEDULE) begin
            if (!req_delay[24] && !match_found && !free_found) begin
              res_status <= ST_FULL;
            end else begin
              res_status <= ST_OK;
            end
          end else if (best_found) begin
            res_status   <= ST_FIRED;
            res_handler  <= best_handler;
            res_argument <= best_argument;
          end else begin
            res_status <= ST_IDLE;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            fired_handler  <= res_handler;
            fired_argument <= res_argument;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/kteq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kteq_checker
// Port-level checks for the keyed timer event queue, bound to the top level.
// ----------------------------------------------------------------------------
module kteq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [31:0] fired_handler,
  input logic [31:0] fired_argument
);
  import kteq_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)
      && $stable(fired_handler) && $stable(fired_argument))
    else $error("output beat changed while stalled");

  // one beat in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a beat is in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK) || (status == ST_FULL) || (status == ST_FIRED)
      || (status == ST_IDLE) || (status == ST_TICK))
    else $error("status code out of range");

  a_fired_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_FIRED) |-> (fired_handler == 32'd0)
      && (fired_argument == 32'd0))
    else $error("fired fields set without a fired event");

endmodule

bind keyed_timer_event_queue kteq_checker u_kteq_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .fired_handler  (fired_handler),
  .fired_argument (fired_argument)
);

[verif/keyed_timer_event_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_timer_event_queue_tb
// Self-checking bench for the keyed timer event queue. A local predictor
// keeps its own copy of the slot table and the millisecond clock. Every
// accepted beat is predicted and queued, and each output beat is checked
// field by field against the oldest prediction. Directed beats cover
// insert, move, cancel, ties, table full and nothing due. Random traffic
// follows, drawn mostly from a small key pool so that keys match and the
// table fills, with random idling on both sides, a long output hold-off
// and pauses until all results are back.
// ----------------------------------------------------------------------------
module keyed_timer_event_queue_tb;
  import kteq_pkg::*;

  localparam int EVENT_SLOTS = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] handler;
    logic [31:0] argument;
  } outcome_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         opcode;
  logic [31:0]        handler_id;
  logic [31:0]        argument;
  logic signed [24:0] delay_ms;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         status;
  logic [31:0]        fired_handler;
  logic [31:0]        fired_argument;

  // predictor copy of the timer table
  logic        timer_live [EVENT_SLOTS];
  logic [31:0] timer_hid  [EVENT_SLOTS];
  logic [31:0] timer_arg  [EVENT_SLOTS];
  logic [31:0] timer_due  [EVENT_SLOTS];
  logic [31:0] now_ms;

  outcome_t pending_outcomes[$];

  int mismatch_count;
  int beats_sent;
  int fired_count;
  int full_count;
  int nothing_due_count;
  int tick_count;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_left;

  keyed_timer_event_queue #(
    .EVENT_SLOTS(EVENT_SLOTS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .handler_id    (handler_id),
    .argument      (argument),
    .delay_ms      (delay_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .fired_handler (fired_handler),
    .fired_argument(fired_argument)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic outcome_t predict_outcome(input logic [1:0] op, input logic [31:0] h,
                                               input logic [31:0] a, input logic [24:0] d);
    outcome_t    r;
    int          hit;
    int          best;
    logic [31:0] age;
    logic [31:0] best_age;
    logic        placed;
    r        = '{status: ST_OK, handler: 32'd0, argument: 32'd0};
    hit      = -1;
    best     = -1;
    best_age = 32'd0;
    placed   = 1'b0;
    case (op)
      OP_SCHEDULE: begin
        for (int i = 0; i < EVENT_SLOTS; i++) begin
          if (hit < 0 && timer_live[i] && timer_hid[i] == h && timer_arg[i] == a) hit = i;
        end
        if (d[24]) begin
          if (hit >= 0) timer_live[hit] = 1'b0;
        end else if (hit >= 0) begin
          timer_due[hit] = now_ms + {8'd0, d[23:0]};
        end else begin
          for (int i = 0; i < EVENT_SLOTS; i++) begin
            if (!placed && !timer_live[i]) begin
              timer_live[i] = 1'b1;
              timer_hid[i]  = h;
              timer_arg[i]  = a;
              timer_due[i]  = now_ms + {8'd0, d[23:0]};
              placed        = 1'b1;
            end
          end
          if (!placed) r.status = ST_FULL;
        end
      end
      OP_TICK: begin
        now_ms   = now_ms + 32'd1;
        r.status = ST_TICK;
      end
      OP_SERVICE: begin
        for (int i = 0; i < EVENT_SLOTS; i++) begin
          age = now_ms - timer_due[i];
          if (timer_live[i] && !age[31] && (best < 0 || age > best_age)) begin
            best     = i;
            best_age = age;
          end
        end
        if (best >= 0) begin
          r.status         = ST_FIRED;
          r.handler        = timer_hid[best];
          r.argument       = timer_arg[best];
          timer_live[best] = 1'b0;
        end else begin
          r.status = ST_IDLE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [31:0] h, input logic [31:0] a,
                           input logic [24:0] d);
    outcome_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    opcode     <= op;
    handler_id <= h;
    argument   <= a;
    delay_ms   <= d;
    do @(posedge clk); while (in_stall);
    r = predict_outcome(op, h, a, d);
    pending_outcomes.push_back(r);
    beats_sent++;
    case (r.status)
      ST_FIRED: fired_count++;
      ST_FULL:  full_count++;
      ST_IDLE:  nothing_due_count++;
      ST_TICK:  tick_count++;
      default: ;
    endcase
  endtask

  task automatic wait_for_outcomes();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall, or a counted hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_left > 0) begin
        out_stall <= 1'b1;
        recv_hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected output beat: status %0d", status);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatch_count++;
        end
        if (fired_handler !== want.handler) begin
          $error("fired_handler: expected %08h, got %08h", want.handler, fired_handler);
          mismatch_count++;
        end
        if (fired_argument !== want.argument) begin
          $error("fired_argument: expected %08h, got %08h", want.argument, fired_argument);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [24:0] pick_delay();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return 25'($urandom_range(30));
    if (sel < 80) return {1'b1, 24'($urandom)};
    if (sel < 90) return 25'($urandom);
    case ($urandom_range(3))
      0: return 25'h0000000;
      1: return 25'h0FFFFFF;
      2: return 25'h1FFFFFF;
      default: return 25'h1000000;
    endcase
  endfunction

  task automatic send_random_beat();
    int          sel;
    int          hsel;
    logic [31:0] h;
    logic [31:0] a;
    sel = $urandom_range(99);
    if (sel < 40) begin
      if ($urandom_range(99) < 80) begin
        hsel = $urandom_range(5);
        h    = (hsel == 5) ? 32'hFFFF_FFFF : hsel * 32'h1357_9BDF;
        a    = 32'($urandom_range(3));
      end else begin
        h = $urandom;
        a = $urandom;
      end
      send_beat(OP_SCHEDULE, h, a, pick_delay());
    end else if (sel < 72) begin
      send_beat(OP_TICK, $urandom, $urandom, 25'($urandom));
    end else if (sel < 95) begin
      send_beat(OP_SERVICE, $urandom, $urandom, 25'($urandom));
    end else begin
      send_beat(OP_NONE, $urandom, $urandom, 25'($urandom));
    end
  endtask

  task automatic test_schedule_and_service();
    send_beat(OP_SCHEDULE, 32'd0, 32'd0, 25'd0);
    send_beat(OP_SERVICE, 32'd0, 32'd0, 25'd0);
    send_beat(OP_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 25'h1FFFFFF);
    send_beat(OP_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 25'h0FFFFFF);
    send_beat(OP_SCHEDULE, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 25'd3);
    send_beat(OP_SCHEDULE, 32'd1, 32'd2, 25'd1);
    send_beat(OP_SCHEDULE, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 25'd0);
    send_beat(OP_TICK, 32'd0, 32'd0, 25'd0);
    send_beat(OP_SERVICE, 32'd0, 32'd0, 25'd0);
    send_beat(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 25'h1FFFFFF);
    send_beat(OP_SERVICE, 32'd0, 32'd0, 25'd0);
    send_beat(OP_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 25'h1000000);
    send_beat(OP_SERVICE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 25'h1FFFFFF);
  endtask

  task automatic test_ties_and_table_full();
    for (int i = 0; i < EVENT_SLOTS; i++) begin
      send_beat(OP_SCHEDULE, 32'h100 + i, 32'(i), 25'd0);
    end
    send_beat(OP_SCHEDULE, 32'hDEAD_0000, 32'h0000_BEEF, 25'd0);
    send_beat(OP_SERVICE, 32'd0, 32'd0, 25'd0);
  endtask

  task automatic test_random_traffic(input int beats, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < beats; i++) send_random_beat();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    recv_hold_left = 300;
    for (int i = 0; i < 40; i++) send_random_beat();
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    opcode         = OP_SCHEDULE;
    handler_id     = 32'd0;
    argument       = 32'd0;
    delay_ms       = 25'sd0;
    mismatch_count = 0;
    beats_sent     = 0;
    fired_count    = 0;
    full_count     = 0;
    nothing_due_count = 0;
    tick_count     = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    recv_hold_left = 0;
    now_ms         = 32'd0;
    for (int i = 0; i < EVENT_SLOTS; i++) begin
      timer_live[i] = 1'b0;
      timer_hid[i]  = 32'd0;
      timer_arg[i]  = 32'd0;
      timer_due[i]  = 32'd0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_schedule_and_service();
    test_ties_and_table_full();
    wait_for_outcomes();
    test_random_traffic(400, 22, 88);
    wait_for_outcomes();
    test_random_traffic(400, 88, 22);
    wait_for_outcomes();
    test_output_hold_off();
    test_random_traffic(400, 0, 0);
    wait_for_outcomes();
    repeat (40) @(posedge clk);

    if (pending_outcomes.size() != 0) begin
      $error("%0d expected output beats never arrived", pending_outcomes.size());
      mismatch_count++;
    end
    $display("covered %0d beats: %0d fired, %0d table full, %0d nothing due, %0d ticks",
             beats_sent, fired_count, full_count, nothing_due_count, tick_count);
    $display("idling on either side, a 300-cycle output hold-off, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
